[rtl/core/imwf_pkg.sv]
// Shared types, constants and a helper function of the invariant mass window filter.
`default_nettype none

package imwf_pkg;

  localparam int MAX_PARTICLES_DEF = 64;
  localparam int NUM_CODES_DEF     = 4;
  localparam int CODE_SLOTS        = 4;

  localparam int COUNT_W    = 7;
  localparam int COUNT_MAX  = 127;
  localparam int MASS_W     = 31;
  localparam int MASS_SQ_W  = 2 * MASS_W;
  localparam int ID_W       = 32;
  localparam int MOM_W      = 32;
  localparam int STATUS_W   = 5;
  localparam int SUM_W      = 38;
  localparam int SPLIT_W    = 32;
  localparam int HI_W       = SUM_W - SPLIT_W;
  localparam int LL_W       = 2 * SPLIT_W;
  localparam int HL_W       = HI_W + SPLIT_W;
  localparam int HH_W       = 2 * HI_W;
  localparam int SQ_W       = 75;
  localparam int P2_W       = 77;
  localparam int LANES      = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int S_DATA_W   = 168;
  localparam int M_DATA_W   = 8;

  // Bit positions of the fields in the input tdata.
  localparam int STATUS_LSB  = 0;
  localparam int SPECIES_LSB = STATUS_LSB + STATUS_W;
  localparam int MOM_X_LSB   = SPECIES_LSB + ID_W;
  localparam int MOM_Y_LSB   = MOM_X_LSB + MOM_W;
  localparam int MOM_Z_LSB   = MOM_Y_LSB + MOM_W;
  localparam int ENERGY_LSB  = MOM_Z_LSB + MOM_W;

  localparam logic [STATUS_W-1:0] STATUS_OUTGOING   = 5'd1;
  localparam logic [COUNT_W-1:0]  NUM_REQUIRED_RST  = 7'd2;
  localparam logic [MASS_W-1:0]   MIN_MASS_RST      = 31'd0;
  localparam logic [MASS_W-1:0]   MAX_MASS_RST      = 31'h7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_REQUIRED = 3'd0,
    REG_MIN_MASS     = 3'd1,
    REG_MAX_MASS     = 3'd2,
    REG_MATCH_ID_A   = 3'd3,
    REG_MATCH_ID_B   = 3'd4,
    REG_MATCH_ID_C   = 3'd5,
    REG_MATCH_ID_D   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [COUNT_W-1:0]                num_required;
    logic [MASS_W-1:0]                 min_mass;
    logic [MASS_W-1:0]                 max_mass;
    logic [CODE_SLOTS-1:0][ID_W-1:0]   code_abs;
    logic [CODE_SLOTS-1:0]             code_used;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;
    logic [SUM_W-1:0]   sum_z;
    logic [SUM_W-1:0]   sum_energy;
    logic [COUNT_W-1:0] count;
  } snap_t;

  // Absolute value of a 32-bit code; the most negative code yields 2^31.
  function automatic logic [ID_W-1:0] abs_id(input logic [ID_W-1:0] v);
    return v[ID_W-1] ? (~v + ID_W'(1)) : v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/invariant_mass_window_filter.sv]
// Throughput: one item per cycle, including back-to-back event ends, as long as the
// mass pipeline can take each snapshot; a last item waits for snap_ready. Each item
// passes one input register and one accumulate step, and the squared mass runs in an
// 8-stage pipeline. Reset: synchronous, active high; clears the accumulators and all
// valid flags and loads the configuration registers with their reset values.
`default_nettype none

module invariant_mass_window_filter #(
  parameter int MAX_PARTICLES = imwf_pkg::MAX_PARTICLES_DEF,
  parameter int NUM_CODES     = imwf_pkg::NUM_CODES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // status[4:0], species[36:5], mom_x[68:37], mom_y[100:69], mom_z[132:101],
  // energy[164:133], zero padding[167:165]
  input  wire logic [imwf_pkg::S_DATA_W-1:0]    s_tdata,
  input  wire logic                             s_tlast,
  // particle_valid[0]
  input  wire logic                             s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // accept[0], matched_total[7:1]
  output logic [imwf_pkg::M_DATA_W-1:0]         m_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [imwf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [imwf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  imwf_pkg::cfg_t  cfg;
  imwf_pkg::snap_t snap;
  logic            snap_valid;
  logic            snap_ready;

  imwf_cfg #(
    .NUM_CODES (NUM_CODES)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  imwf_accum #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .s_tuser    (s_tuser),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready)
  );

  imwf_mass u_mass (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

[rtl/core/imwf_cfg.sv]
// Configuration registers and the derived match-code magnitudes.
`default_nettype none

module imwf_cfg #(
  parameter int NUM_CODES = imwf_pkg::NUM_CODES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [imwf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [imwf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output imwf_pkg::cfg_t                        cfg
);

  logic [imwf_pkg::COUNT_W-1:0] num_required;
  logic [imwf_pkg::MASS_W-1:0]  min_mass;
  logic [imwf_pkg::MASS_W-1:0]  max_mass;
  logic [imwf_pkg::ID_W-1:0]    match_id [imwf_pkg::CODE_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      num_required <= imwf_pkg::NUM_REQUIRED_RST;
      min_mass     <= imwf_pkg::MIN_MASS_RST;
      max_mass     <= imwf_pkg::MAX_MASS_RST;
      for (int k = 0; k < imwf_pkg::CODE_SLOTS; k++) begin
        match_id[k] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        imwf_pkg::REG_NUM_REQUIRED: num_required <= cfg_data[imwf_pkg::COUNT_W-1:0];
        imwf_pkg::REG_MIN_MASS:     min_mass     <= cfg_data[imwf_pkg::MASS_W-1:0];
        imwf_pkg::REG_MAX_MASS:     max_mass     <= cfg_data[imwf_pkg::MASS_W-1:0];
        imwf_pkg::REG_MATCH_ID_A:   match_id[0]  <= cfg_data[imwf_pkg::ID_W-1:0];
        imwf_pkg::REG_MATCH_ID_B:   match_id[1]  <= cfg_data[imwf_pkg::ID_W-1:0];
        imwf_pkg::REG_MATCH_ID_C:   match_id[2]  <= cfg_data[imwf_pkg::ID_W-1:0];
        imwf_pkg::REG_MATCH_ID_D:   match_id[3]  <= cfg_data[imwf_pkg::ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.num_required = num_required;
    cfg.min_mass     = min_mass;
    cfg.max_mass     = max_mass;
    for (int k = 0; k < imwf_pkg::CODE_SLOTS; k++) begin
      cfg.code_abs[k]  = imwf_pkg::abs_id(match_id[k]);
      // A zero code is an unused slot, and slots beyond NUM_CODES never match.
      cfg.code_used[k] = (k < NUM_CODES) && (match_id[k] != '0);
    end
  end

endmodule

`default_nettype wire

[rtl/core/imwf_accum.sv]
// Input register, species match and the per-event four-momentum accumulators.
`default_nettype none

module imwf_accum #(
  parameter int MAX_PARTICLES = imwf_pkg::MAX_PARTICLES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire imwf_pkg::cfg_t                 cfg,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [imwf_pkg::S_DATA_W-1:0]  s_tdata,
  input  wire logic                           s_tlast,
  input  wire logic                           s_tuser,
  output logic                                snap_valid,
  output imwf_pkg::snap_t                     snap,
  input  wire logic                           snap_ready
);

  localparam int LimitInt = (MAX_PARTICLES < imwf_pkg::COUNT_MAX) ? MAX_PARTICLES
                                                                  : imwf_pkg::COUNT_MAX;
  localparam logic [imwf_pkg::COUNT_W-1:0] CountLimit = imwf_pkg::COUNT_W'(LimitInt);

  logic                          in_valid;
  logic                          in_last;
  logic                          in_hit;
  logic [imwf_pkg::MOM_W-1:0]    in_mom [imwf_pkg::LANES];

  logic [imwf_pkg::SUM_W-1:0]    sum      [imwf_pkg::LANES];
  logic [imwf_pkg::SUM_W-1:0]    sum_next [imwf_pkg::LANES];
  logic [imwf_pkg::COUNT_W-1:0]  count;
  logic [imwf_pkg::COUNT_W-1:0]  count_next;

  logic                          hit;
  logic [imwf_pkg::ID_W-1:0]     species_abs;
  logic                          consume;

  // Match decision is taken on the raw input so that the register holds one flag.
  always_comb begin
    species_abs = imwf_pkg::abs_id(s_tdata[imwf_pkg::SPECIES_LSB +: imwf_pkg::ID_W]);
    hit = 1'b0;
    for (int k = 0; k < imwf_pkg::CODE_SLOTS; k++) begin
      if (cfg.code_used[k] && (cfg.code_abs[k] == species_abs)) begin
        hit = 1'b1;
      end
    end
    hit = hit && s_tuser &&
          (s_tdata[imwf_pkg::STATUS_LSB +: imwf_pkg::STATUS_W] == imwf_pkg::STATUS_OUTGOING);
  end

  // A last item leaves only when the mass pipeline can take its snapshot.
  assign consume  = in_valid && (!in_last || snap_ready);
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_last   <= s_tlast;
      in_hit    <= hit;
      in_mom[0] <= s_tdata[imwf_pkg::MOM_X_LSB  +: imwf_pkg::MOM_W];
      in_mom[1] <= s_tdata[imwf_pkg::MOM_Y_LSB  +: imwf_pkg::MOM_W];
      in_mom[2] <= s_tdata[imwf_pkg::MOM_Z_LSB  +: imwf_pkg::MOM_W];
      in_mom[3] <= s_tdata[imwf_pkg::ENERGY_LSB +: imwf_pkg::MOM_W];
    end
  end

  always_comb begin
    for (int i = 0; i < imwf_pkg::LANES; i++) begin
      sum_next[i] = in_hit ? (sum[i] + imwf_pkg::SUM_W'($signed(in_mom[i]))) : sum[i];
    end
    count_next = (in_hit && (count < CountLimit)) ? (count + imwf_pkg::COUNT_W'(1)) : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < imwf_pkg::LANES; i++) begin
        sum[i] <= '0;
      end
    end else if (consume) begin
      if (in_last) begin
        count <= '0;
        for (int i = 0; i < imwf_pkg::LANES; i++) begin
          sum[i] <= '0;
        end
      end else begin
        count <= count_next;
        for (int i = 0; i < imwf_pkg::LANES; i++) begin
          sum[i] <= sum_next[i];
        end
      end
    end
  end

  assign snap_valid      = in_valid && in_last;
  assign snap.sum_x      = sum_next[0];
  assign snap.sum_y      = sum_next[1];
  assign snap.sum_z      = sum_next[2];
  assign snap.sum_energy = sum_next[3];
  assign snap.count      = count_next;

endmodule

`default_nettype wire

[rtl/core/imwf_mass.sv]
// Squared-mass pipeline: magnitudes, split squares, sums, window test and result register.
`default_nettype none

module imwf_mass (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire imwf_pkg::cfg_t                 cfg,
  input  wire logic                           snap_valid,
  input  wire imwf_pkg::snap_t                snap,
  output logic                                snap_ready,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [imwf_pkg::M_DATA_W-1:0]       m_tdata
);

  localparam int Lx = 0;
  localparam int Ly = 1;
  localparam int Lz = 2;
  localparam int Le = 3;
  localparam int Stages = 8;

  logic [Stages:1] v;
  logic [Stages:1] en;

  logic [imwf_pkg::SUM_W-1:0]     s1_sum [imwf_pkg::LANES];
  logic [imwf_pkg::SUM_W-1:0]     s2_mag [imwf_pkg::LANES];
  logic [imwf_pkg::LL_W-1:0]      s3_ll  [imwf_pkg::LANES];
  logic [imwf_pkg::HL_W-1:0]      s3_hl  [imwf_pkg::LANES];
  logic [imwf_pkg::HH_W-1:0]      s3_hh  [imwf_pkg::LANES];
  logic [imwf_pkg::SQ_W-1:0]      s4_sq  [imwf_pkg::LANES];
  logic [imwf_pkg::P2_W-1:0]      s5_pxy;
  logic [imwf_pkg::SQ_W-1:0]      s5_z2;
  logic [imwf_pkg::SQ_W-1:0]      s5_e2;
  logic [imwf_pkg::P2_W-1:0]      s6_p2;
  logic [imwf_pkg::SQ_W-1:0]      s6_e2;
  logic [imwf_pkg::P2_W-1:0]      s7_lo;
  logic [imwf_pkg::P2_W-1:0]      s7_hi;
  logic [imwf_pkg::SQ_W-1:0]      s7_e2;
  logic [imwf_pkg::COUNT_W-1:0]   cnt [1:Stages-1];
  logic                           accept;
  logic [imwf_pkg::COUNT_W-1:0]   matched_total;

  // Squared limits track cfg; users change cfg only while the block is idle, unchecked here.
  logic [imwf_pkg::MASS_SQ_W-1:0] min_sq;
  logic [imwf_pkg::MASS_SQ_W-1:0] max_sq;

  // A stage moves when it is empty or the stage after it moves, so bubbles close up.
  always_comb begin
    en[Stages] = !v[Stages] || m_tready;
    for (int k = Stages - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign snap_ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= snap_valid;
      end
      for (int k = 2; k <= Stages; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    min_sq <= imwf_pkg::MASS_SQ_W'(cfg.min_mass) * imwf_pkg::MASS_SQ_W'(cfg.min_mass);
    max_sq <= imwf_pkg::MASS_SQ_W'(cfg.max_mass) * imwf_pkg::MASS_SQ_W'(cfg.max_mass);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_sum[Lx] <= snap.sum_x;
      s1_sum[Ly] <= snap.sum_y;
      s1_sum[Lz] <= snap.sum_z;
      s1_sum[Le] <= snap.sum_energy;
      cnt[1]     <= snap.count;
    end
    if (en[2]) begin
      for (int i = 0; i < imwf_pkg::LANES; i++) begin
        s2_mag[i] <= s1_sum[i][imwf_pkg::SUM_W-1] ? (~s1_sum[i] + imwf_pkg::SUM_W'(1))
                                                 : s1_sum[i];
      end
      cnt[2] <= cnt[1];
    end
    // Each magnitude is split at bit 32: m^2 = lo^2 + 2*hi*lo*2^32 + hi^2*2^64.
    if (en[3]) begin
      for (int i = 0; i < imwf_pkg::LANES; i++) begin
        s3_ll[i] <= imwf_pkg::LL_W'(s2_mag[i][imwf_pkg::SPLIT_W-1:0]) *
                    imwf_pkg::LL_W'(s2_mag[i][imwf_pkg::SPLIT_W-1:0]);
        s3_hl[i] <= imwf_pkg::HL_W'(s2_mag[i][imwf_pkg::SUM_W-1:imwf_pkg::SPLIT_W]) *
                    imwf_pkg::HL_W'(s2_mag[i][imwf_pkg::SPLIT_W-1:0]);
        s3_hh[i] <= imwf_pkg::HH_W'(s2_mag[i][imwf_pkg::SUM_W-1:imwf_pkg::SPLIT_W]) *
                    imwf_pkg::HH_W'(s2_mag[i][imwf_pkg::SUM_W-1:imwf_pkg::SPLIT_W]);
      end
      cnt[3] <= cnt[2];
    end
    if (en[4]) begin
      for (int i = 0; i < imwf_pkg::LANES; i++) begin
        s4_sq[i] <= imwf_pkg::SQ_W'(s3_ll[i]) +
                    (imwf_pkg::SQ_W'(s3_hl[i]) << (imwf_pkg::SPLIT_W + 1)) +
                    (imwf_pkg::SQ_W'(s3_hh[i]) << (2 * imwf_pkg::SPLIT_W));
      end
      cnt[4] <= cnt[3];
    end
    if (en[5]) begin
      s5_pxy <= imwf_pkg::P2_W'(s4_sq[Lx]) + imwf_pkg::P2_W'(s4_sq[Ly]);
      s5_z2  <= s4_sq[Lz];
      s5_e2  <= s4_sq[Le];
      cnt[5] <= cnt[4];
    end
    if (en[6]) begin
      s6_p2  <= s5_pxy + imwf_pkg::P2_W'(s5_z2);
      s6_e2  <= s5_e2;
      cnt[6] <= cnt[5];
    end
    // min^2 < E^2 - p^2 < max^2 is tested as E^2 > p^2 + min^2 and p^2 + max^2 > E^2.
    if (en[7]) begin
      s7_lo  <= s6_p2 + imwf_pkg::P2_W'(min_sq);
      s7_hi  <= s6_p2 + imwf_pkg::P2_W'(max_sq);
      s7_e2  <= s6_e2;
      cnt[7] <= cnt[6];
    end
    if (en[8]) begin
      accept <= (cnt[7] == cfg.num_required) &&
                (imwf_pkg::P2_W'(s7_e2) > s7_lo) &&
                (s7_hi > imwf_pkg::P2_W'(s7_e2));
      matched_total <= cnt[7];
    end
  end

  assign m_tvalid = v[Stages];
  assign m_tdata  = {matched_total, accept};

endmodule

`default_nettype wire

[rtl/core/imwf_checker.sv]
// Port-level assertions for the invariant mass window filter, bound to the top level.
`default_nettype none

module imwf_checker #(
  parameter int MAX_PARTICLES = imwf_pkg::MAX_PARTICLES_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tready,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [imwf_pkg::M_DATA_W-1:0] m_tdata
);

  localparam int LimitInt = (MAX_PARTICLES < imwf_pkg::COUNT_MAX) ? MAX_PARTICLES
                                                                  : imwf_pkg::COUNT_MAX;
  localparam logic [imwf_pkg::COUNT_W-1:0] CountLimit = imwf_pkg::COUNT_W'(LimitInt);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // With no result waiting the whole pipeline can move, so input is always taken.
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // Checks that an accepted event has a count from one up to the counter limit.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |->
      (m_tdata[imwf_pkg::M_DATA_W-1:1] != '0) &&
      (m_tdata[imwf_pkg::M_DATA_W-1:1] <= CountLimit))
    else $error("accepted event with impossible count");

endmodule

bind invariant_mass_window_filter imwf_checker #(
  .MAX_PARTICLES (MAX_PARTICLES)
) u_imwf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[test/invariant_mass_window_filter_tb.sv]
// Self-checking testbench of the invariant mass window filter: random streams against a model.
`timescale 1ns / 1ps

module invariant_mass_window_filter_tb;

  localparam int COUNT_LIMIT = (imwf_pkg::MAX_PARTICLES_DEF < imwf_pkg::COUNT_MAX) ?
                               imwf_pkg::MAX_PARTICLES_DEF : imwf_pkg::COUNT_MAX;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic        present;
    logic [4:0]  status;
    logic [31:0] species;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] en;
    logic        last;
    bit          drain;
  } particle_t;

  typedef struct {
    logic       accept;
    logic [6:0] total;
  } decision_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [imwf_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [imwf_pkg::M_DATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [imwf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [imwf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  particle_t particles_waiting[$];
  decision_t decisions_due[$];

  // Model copy of the configuration, tracking every register write.
  logic [6:0]  want_count = imwf_pkg::NUM_REQUIRED_RST;
  logic [30:0] lo_mass = imwf_pkg::MIN_MASS_RST;
  logic [30:0] hi_mass = imwf_pkg::MAX_MASS_RST;
  logic [31:0] codes[imwf_pkg::CODE_SLOTS] = '{default: '0};

  // Model copy of the event accumulators.
  logic [6:0]  hit_count = '0;
  logic [37:0] acc_x = '0, acc_y = '0, acc_z = '0, acc_e = '0;

  int  decided_count = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  cycles = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;
  bit  drain_next = 1'b0;

  invariant_mass_window_filter dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic logic [37:0] mag38(input logic [37:0] s);
    return s[37] ? -s : s;
  endfunction

  function automatic logic [79:0] square80(input logic [79:0] v);
    return v * v;
  endfunction

  function automatic bit species_hit(input logic [31:0] sp);
    for (int k = 0; k < imwf_pkg::NUM_CODES_DEF; k++) begin
      if (codes[k] != '0 && abs32(codes[k]) == abs32(sp)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in calm stretches.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Accumulates one accepted item and, on the last item of an event, predicts the decision.
  task automatic fold_particle(input particle_t p);
    logic [79:0] e_sq, p_sq, lo_sq, hi_sq;
    decision_t d;
    if (p.present && p.status == imwf_pkg::STATUS_OUTGOING && species_hit(p.species)) begin
      if (hit_count < COUNT_LIMIT) hit_count++;
      acc_x += {{6{p.px[31]}}, p.px};
      acc_y += {{6{p.py[31]}}, p.py};
      acc_z += {{6{p.pz[31]}}, p.pz};
      acc_e += {{6{p.en[31]}}, p.en};
    end
    if (p.last) begin
      e_sq = square80(mag38(acc_e));
      p_sq = square80(mag38(acc_x)) + square80(mag38(acc_y)) + square80(mag38(acc_z));
      lo_sq = p_sq + square80(lo_mass);
      hi_sq = p_sq + square80(hi_mass);
      d.accept = (hit_count == want_count) && (e_sq > lo_sq) && (hi_sq > e_sq);
      d.total = hit_count;
      decisions_due.push_back(d);
      decided_count++;
      hit_count = '0;
      acc_x = '0;
      acc_y = '0;
      acc_z = '0;
      acc_e = '0;
    end
  endtask

  // Sender side.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        fold_particle(particles_waiting.pop_front());
        gap_left = pick_gap();
      end
      if (s_tvalid && !s_tready) begin
        // Holding the current item until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (particles_waiting.size() != 0 &&
                   !(particles_waiting[0].drain && decided_count != results_seen)) begin
        s_tvalid <= 1'b1;
        s_tuser <= particles_waiting[0].present;
        s_tlast <= particles_waiting[0].last;
        s_tdata <= {3'b000, particles_waiting[0].en, particles_waiting[0].pz,
                    particles_waiting[0].py, particles_waiting[0].px,
                    particles_waiting[0].species, particles_waiting[0].status};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver side.
  always @(posedge clk) begin
    decision_t d;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (decisions_due.size() == 0) begin
          report_mismatch($sformatf("unexpected decision 0x%02h", m_tdata));
        end else begin
          d = decisions_due.pop_front();
          results_seen <= results_seen + 1;
          if (m_tdata[0] !== d.accept || m_tdata[7:1] !== d.total)
            report_mismatch($sformatf("decision %0d: accept %b/%b total %0d/%0d (got/want)",
                                      results_seen, m_tdata[0], d.accept, m_tdata[7:1],
                                      d.total));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("invariant_mass_window_filter regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input imwf_pkg::cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      imwf_pkg::REG_NUM_REQUIRED: want_count = val[6:0];
      imwf_pkg::REG_MIN_MASS:     lo_mass = val[30:0];
      imwf_pkg::REG_MAX_MASS:     hi_mass = val[30:0];
      imwf_pkg::REG_MATCH_ID_A:   codes[0] = val;
      imwf_pkg::REG_MATCH_ID_B:   codes[1] = val;
      imwf_pkg::REG_MATCH_ID_C:   codes[2] = val;
      imwf_pkg::REG_MATCH_ID_D:   codes[3] = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_window(input int req, input logic [31:0] lo, input logic [31:0] hi);
    write_reg(imwf_pkg::REG_NUM_REQUIRED, req);
    write_reg(imwf_pkg::REG_MIN_MASS, lo);
    write_reg(imwf_pkg::REG_MAX_MASS, hi);
  endtask

  task automatic set_codes(input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [31:0] d);
    write_reg(imwf_pkg::REG_MATCH_ID_A, a);
    write_reg(imwf_pkg::REG_MATCH_ID_B, b);
    write_reg(imwf_pkg::REG_MATCH_ID_C, c);
    write_reg(imwf_pkg::REG_MATCH_ID_D, d);
  endtask

  // Waits until every item is taken and every decision is in, then lets the pipeline empty.
  task automatic settle();
    @(negedge clk);
    while (particles_waiting.size() != 0 || decisions_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void push_item(input logic present, input int st, input logic [31:0] sp,
                                    input logic [31:0] px, input logic [31:0] py,
                                    input logic [31:0] pz, input logic [31:0] en,
                                    input logic last);
    particle_t p;
    p.present = present;
    p.status = 5'(st);
    p.species = sp;
    p.px = px;
    p.py = py;
    p.pz = pz;
    p.en = en;
    p.last = last;
    p.drain = 1'b0;
    particles_waiting.push_back(p);
  endfunction

  function automatic logic [31:0] rand_code();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r == 2) return $urandom;
    if (r == 3) return 32'h8000_0000;
    return $urandom_range(0, 1) ? -$urandom_range(1, 400) : $urandom_range(1, 400);
  endfunction

  // A species that one of the live code slots accepts, of either sign, or any value when no slot is live.
  function automatic logic [31:0] live_species();
    logic [31:0] used[$];
    logic [31:0] sp;
    for (int k = 0; k < imwf_pkg::NUM_CODES_DEF; k++) if (codes[k] != '0) used.push_back(codes[k]);
    if (used.size() == 0) return $urandom;
    sp = used[$urandom_range(0, used.size() - 1)];
    return $urandom_range(0, 1) ? -sp : sp;
  endfunction

  // A physical particle (energy at least the momentum), or, for a miss, one that fails
  // the match on status, emptiness or species; a noisy particle has random fields.
  function automatic particle_t make_particle(input bit hit, input bit noisy);
    particle_t p;
    int st;
    p.present = 1'b1;
    p.status = imwf_pkg::STATUS_OUTGOING;
    p.species = live_species();
    p.last = 1'b0;
    p.drain = 1'b0;
    p.px = $urandom_range(0, 8191) - 4096;
    p.py = $urandom_range(0, 8191) - 4096;
    p.pz = $urandom_range(0, 8191) - 4096;
    p.en = abs32(p.px) + abs32(p.py) + abs32(p.pz) + $urandom_range(0, 4095);
    if (noisy) begin
      p.present = $urandom_range(0, 3) != 0;
      p.status = 5'($urandom_range(0, 12) - 9);
      if ($urandom_range(0, 1)) p.species = $urandom;
      p.px = $urandom;
      p.py = $urandom;
      p.pz = $urandom;
      p.en = $urandom;
    end else if (!hit) begin
      case ($urandom_range(0, 2))
        0: begin
          do st = $urandom_range(0, 12) - 9; while (st == 1);
          p.status = 5'(st);
        end
        1: p.present = 1'b0;
        default: p.species = $urandom;
      endcase
    end
    return p;
  endfunction

  // Queues one event and returns the number of items it took.
  function automatic int queue_event(input int hits, input int extras, input bit noisy);
    particle_t p;
    int left, hits_left;
    left = hits + extras;
    hits_left = hits;
    for (int i = 0; i < hits + extras; i++) begin
      p = make_particle($urandom_range(1, left) <= hits_left, noisy);
      if (p.present && p.status == imwf_pkg::STATUS_OUTGOING && hits_left > 0) hits_left--;
      left--;
      if (i == 0) begin
        p.drain = drain_next || ($urandom_range(0, 39) == 0);
        drain_next = 1'b0;
      end
      particles_waiting.push_back(p);
    end
    // Either the last particle closes the event or an empty item follows it.
    if (hits + extras == 0 || $urandom_range(0, 4) == 0) begin
      push_item(1'b0, $urandom_range(0, 12) - 9, $urandom, $urandom, $urandom, $urandom,
                $urandom, 1'b1);
      particles_waiting[$].drain = drain_next;
      drain_next = 1'b0;
      return hits + extras + 1;
    end
    particles_waiting[$].last = 1'b1;
    return hits + extras;
  endfunction

  initial begin
    int phase_items;
    int hits;
    logic [31:0] lo;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: all code slots are unused, so not even species 0 matches.
    push_item(1'b1, 1, 32'd0, 0, 0, 0, 1500, 1'b0);
    push_item(1'b1, 1, 32'd5, 0, 0, 0, 1500, 1'b1);
    settle();

    set_window(1, 1000, 2000);
    set_codes(11, -13, 0, 32'h8000_0000);
    push_item(1'b1, 1, 11, 0, 0, 0, 1000, 1'b1);            // on the lower bound
    push_item(1'b1, 1, -11, 0, 0, 0, 1001, 1'b1);
    push_item(1'b1, 1, 13, 0, 0, 0, 1999, 1'b1);            // sign of code ignored
    push_item(1'b1, 1, 11, 0, 0, 0, 2000, 1'b1);            // on the upper bound
    push_item(1'b1, 1, 32'h8000_0000, 0, 0, 0, 1500, 1'b1); // most negative species
    push_item(1'b1, 1, 0, 0, 0, 0, 1500, 1'b0);
    push_item(1'b1, 1, 11, 0, 0, 0, 1500, 1'b1);
    push_item(1'b1, 0, 11, 0, 0, 0, 1500, 1'b1);
    push_item(1'b1, -9, 11, 0, 0, 0, 1500, 1'b0);
    push_item(1'b1, 3, 13, 0, 0, 0, 1500, 1'b0);
    push_item(1'b0, 1, 11, 0, 0, 0, 1500, 1'b1);            // empty item only closes
    push_item(1'b0, 1, 11, 0, 0, 0, 0, 1'b1);
    push_item(1'b1, 1, 11, 5, 0, 0, 0, 1'b1);               // negative squared mass
    push_item(1'b1, 1, 11, 0, 0, 0, -1500, 1'b1);
    push_item(1'b1, 1, 11, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    push_item(1'b1, 1, 13, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 1'b1);
    push_item(1'b1, 1, 12, 0, 0, 0, 1500, 1'b1);
    push_item(1'b1, 1, 11, 300, -400, 0, 1300, 1'b1);
    settle();

    // Counter saturation, with no gaps on either side.
    calm = 1'b1;
    set_window(64, 0, 32'h7FFF_FFFF);
    set_codes(22, 0, 0, 0);
    void'(queue_event(64, 0, 1'b0));
    void'(queue_event(66, 2, 1'b0));
    void'(queue_event(63, 1, 1'b0));
    settle();
    calm = 1'b0;
    write_reg(imwf_pkg::REG_NUM_REQUIRED, 127);            // beyond what the counter reaches
    void'(queue_event(66, 0, 1'b0));
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      calm = (phase == 4);
      lo = $urandom_range(0, 12000);
      case (phase)
        0: set_window($urandom_range(1, 4), 0, 32'h7FFF_FFFF);
        1: set_window($urandom_range(0, 3), lo, 0);
        2: set_window($urandom_range(1, 3), 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        default: set_window($urandom_range(0, 5), lo, lo + $urandom_range(2000, 40000));
      endcase
      set_codes(rand_code(), rand_code(), rand_code(), rand_code());
      if (codes[0] == '0 && phase != 5) write_reg(imwf_pkg::REG_MATCH_ID_A, 11);
      drain_next = (phase == 2);
      phase_items = 0;
      while (phase_items < 110) begin
        hits = ($urandom_range(0, 9) < 7) ? want_count : $urandom_range(0, want_count + 2);
        phase_items += queue_event(hits, $urandom_range(0, 3), $urandom_range(0, 9) == 0);
      end
      settle();
    end
    calm = 1'b0;

    if (mismatches == 0)
      $display("invariant_mass_window_filter regression: pass");
    else
      $display("invariant_mass_window_filter regression: fail");
    $finish;
  end

endmodule
